>>> src/gb5m_pkg.sv
package gb5m_pkg;

  // Pixel and register widths
  localparam int PIXEL_BITS      = 16;
  localparam int WIDTH_REG_BITS  = 11;
  localparam int HEIGHT_REG_BITS = 13;
  localparam int CFG_DATA_BITS   = 13;
  localparam int CFG_IDX_BITS    = 1;

  // Frame limits and reset geometry
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int MIN_DIM       = 3;
  localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 13'd480;

  // Line store: one bank per row slot
  localparam int ROW_SLOTS = 6;
  localparam int SLOT_BITS = 3;
  localparam int TAPS      = 5;
  localparam int TAP_BITS  = 3;

  // Arithmetic widths: column sum <= 49 * max pixel, total <= 159 * max pixel + 79
  localparam int PSUM_BITS  = 22;
  localparam int SUM_BITS   = 24;
  localparam int RECIP_BITS = 25;
  localparam int RECIP_SHIFT = 32;
  localparam logic [SUM_BITS-1:0]   ROUND_BIAS = 24'd79;
  // ceil(2^32 / 159): exact quotient for every dividend below 2^24
  localparam logic [RECIP_BITS-1:0] RECIP_159  = 25'd27012373;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef pix_t [TAPS-1:0] column_t;

  // Distance back from the current position to the mirrored tap position
  function automatic logic [TAP_BITS-1:0] tap_dist(input logic [TAP_BITS-1:0] t,
                                                   input logic lo,
                                                   input logic [1:0] pos,
                                                   input logic hi,
                                                   input logic [1:0] over);
    logic [3:0] r;
    if (lo && (({1'b0, t} + {2'b00, pos}) < 4'd4)) begin
      r = {1'b0, t} + {1'b0, pos, 1'b0} - 4'd4;
    end else if (hi && (({1'b0, t} + {2'b00, over}) >= 4'd4)) begin
      r = {1'b0, t} + {1'b0, over, 1'b0} - 4'd3;
    end else begin
      r = 4'd4 - {1'b0, t};
    end
    return r[TAP_BITS-1:0];
  endfunction

  // Row slot a given distance behind the current slot, modulo six
  function automatic logic [SLOT_BITS-1:0] slot_back(input logic [SLOT_BITS-1:0] slot,
                                                     input logic [TAP_BITS-1:0] d);
    logic [3:0] s;
    s = {1'b0, slot} + 4'd6 - {1'b0, d};
    if (s >= 4'd6) begin
      s = s - 4'd6;
    end
    return s[SLOT_BITS-1:0];
  endfunction

  // Vertical weighted sum of one column for the given horizontal tap
  function automatic logic [PSUM_BITS-1:0] col_sum(input logic [TAP_BITS-1:0] t,
                                                   input column_t v);
    logic [PSUM_BITS-1:0] outer;
    logic [PSUM_BITS-1:0] inner;
    logic [PSUM_BITS-1:0] mid;
    logic [PSUM_BITS-1:0] r;
    outer = PSUM_BITS'(v[0]) + PSUM_BITS'(v[4]);
    inner = PSUM_BITS'(v[1]) + PSUM_BITS'(v[3]);
    mid   = PSUM_BITS'(v[2]);
    case (t)
      3'd0, 3'd4: r = PSUM_BITS'(outer * 2  + inner * 4  + mid * 5);
      3'd1, 3'd3: r = PSUM_BITS'(outer * 4  + inner * 9  + mid * 12);
      3'd2:       r = PSUM_BITS'(outer * 5  + inner * 12 + mid * 15);
      default:    r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> src/gb5m_ram.sv
module gb5m_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> src/gaussian_blur_5x5_mirror.sv
// Channel  | Direction | Handshake             | Word
// ---------+-----------+-----------------------+---------------------------
// in       | input     | in_valid_i/in_stall_o | kind_i, pixel_in_i
// out      | output    | out_valid_o/out_stall_i| pixel_out_o, frame_last_o
// cfg      | input     | cfg_we_i              | cfg_index_i, cfg_data_i
//
// One word is accepted per cycle unless in_stall_o is high; results leave stage 4,
// and a window is complete 2*width+2 words after the pixel at its centre.
// Six row-slot RAM banks are read at the input column per stepping word; pixels write one.
// Drain words flush the last 2*width+2 results after the final pixel of a frame.
// Reset clears counters and valids; line store contents stay undefined.
// An output stall backs up the four-stage pipe; input stalls only once it is full.
module gaussian_blur_5x5_mirror #(
  parameter int MAX_WIDTH = gb5m_pkg::MAX_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 kind_i,
  input  logic [gb5m_pkg::PIXEL_BITS-1:0]      pixel_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [gb5m_pkg::PIXEL_BITS-1:0]      pixel_out_o,
  output logic                                 frame_last_o,
  input  logic                                 cfg_we_i,
  input  logic [gb5m_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [gb5m_pkg::CFG_DATA_BITS-1:0]   cfg_data_i
);

  import gb5m_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CMP_W = ((COL_W + 1) > WIDTH_REG_BITS) ? (COL_W + 1) : WIDTH_REG_BITS;
  localparam int PROD_BITS = SUM_BITS + RECIP_BITS;

  // Configuration
  logic [WIDTH_REG_BITS-1:0]  width_q;
  logic [HEIGHT_REG_BITS-1:0] height_q;
  logic [WIDTH_REG_BITS-1:0]  cfg_w;
  logic [HEIGHT_REG_BITS-1:0] cfg_h;

  // Stream and output positions
  logic [COL_W-1:0]           s_col_q, s_col_d;
  logic [HEIGHT_REG_BITS-1:0] s_row_q, s_row_d;
  logic [SLOT_BITS-1:0]       slot_q, slot_d;
  logic [COL_W-1:0]           o_col_q, o_col_d;
  logic [HEIGHT_REG_BITS-1:0] o_row_q, o_row_d;

  // Handshake
  logic ready1, ready2, ready3, ready4;
  logic accept;
  logic input_done, pix_step, step, emit, last;
  logic col_wrap;

  // Tap decode at the input
  logic                 row_lo, row_hi, col_lo, col_hi;
  logic [1:0]           row_over, col_pos, col_over;
  logic [TAP_BITS-1:0]  d_tap [TAPS];
  logic [TAP_BITS-1:0]  k_tap [TAPS];
  logic [SLOT_BITS-1:0] slot_tap [TAPS];

  // Stage 1
  logic                 v1_q, emit1_q, last1_q;
  pix_t                 pix1_q;
  logic [TAPS-1:0]      dz1_q;
  logic [SLOT_BITS-1:0] slot1_q [TAPS];
  logic [TAP_BITS-1:0]  k1_q [TAPS];
  pix_t                 rd_data [ROW_SLOTS];

  // Stage 2 and window
  column_t              col_vec;
  column_t              sr_q [TAPS];
  column_t              sr_d [TAPS];
  column_t              sel [TAPS];
  logic                 v2_q, last2_q;
  logic [PSUM_BITS-1:0] psum2_q [TAPS];
  logic [PSUM_BITS-1:0] psum2_d [TAPS];

  // Stages 3 and 4
  logic                 v3_q, last3_q;
  logic [SUM_BITS-1:0]  tot3_q, tot3_d;
  logic                 v4_q, last4_q;
  pix_t                 pix4_q;
  logic [PROD_BITS-1:0] prod;

  // Ready chain through the pipe
  assign ready4     = !v4_q || !out_stall_i;
  assign ready3     = !v3_q || ready4;
  assign ready2     = !v2_q || ready3;
  assign ready1     = !v1_q || ready2;
  assign in_stall_o = !ready1;
  assign accept     = in_valid_i && ready1;

  // Clamp configuration words
  always_comb begin
    cfg_w = cfg_data_i[WIDTH_REG_BITS-1:0];
    if (cfg_w < WIDTH_REG_BITS'(MIN_DIM)) begin
      cfg_w = WIDTH_REG_BITS'(MIN_DIM);
    end else if (32'(cfg_w) > MAX_WIDTH) begin
      cfg_w = WIDTH_REG_BITS'(MAX_WIDTH);
    end
    cfg_h = cfg_data_i[HEIGHT_REG_BITS-1:0];
    if (cfg_h < HEIGHT_REG_BITS'(MIN_DIM)) begin
      cfg_h = HEIGHT_REG_BITS'(MIN_DIM);
    end else if (32'(cfg_h) > MAX_HEIGHT) begin
      cfg_h = HEIGHT_REG_BITS'(MAX_HEIGHT);
    end
  end

  // Classify the word and advance positions
  always_comb begin
    input_done = s_row_q >= height_q;
    pix_step   = !kind_i && !input_done;
    step       = pix_step || input_done;
    emit       = input_done || (s_row_q > HEIGHT_REG_BITS'(2)) ||
                 ((s_row_q == HEIGHT_REG_BITS'(2)) && (s_col_q >= COL_W'(2)));
    last       = emit && (o_row_q == (height_q - 1'b1)) &&
                 (CMP_W'(o_col_q) == (CMP_W'(width_q) - 1'b1));
    col_wrap   = (CMP_W'(s_col_q) + 1'b1) == CMP_W'(width_q);

    s_col_d = s_col_q;
    s_row_d = s_row_q;
    slot_d  = slot_q;
    o_col_d = o_col_q;
    o_row_d = o_row_q;
    if (accept && step) begin
      if (col_wrap) begin
        s_col_d = '0;
        s_row_d = s_row_q + 1'b1;
        slot_d  = (slot_q == SLOT_BITS'(ROW_SLOTS - 1)) ? '0 : slot_q + 1'b1;
      end else begin
        s_col_d = s_col_q + 1'b1;
      end
      if (emit) begin
        if ((CMP_W'(o_col_q) + 1'b1) == CMP_W'(width_q)) begin
          o_col_d = '0;
          o_row_d = o_row_q + 1'b1;
        end else begin
          o_col_d = o_col_q + 1'b1;
        end
      end
      if (last) begin
        s_col_d = '0;
        s_row_d = '0;
        slot_d  = '0;
        o_col_d = '0;
        o_row_d = '0;
      end
    end
  end

  // Decode mirrored taps: rows for the fetched column, columns for the result
  always_comb begin
    row_lo   = s_row_q < HEIGHT_REG_BITS'(4);
    row_hi   = input_done;
    row_over = 2'(s_row_q - height_q);
    col_hi   = s_col_q < COL_W'(2);
    col_lo   = col_hi ? ((width_q == WIDTH_REG_BITS'(MIN_DIM)) && (s_col_q == '0))
                      : (s_col_q < COL_W'(4));
    col_pos  = col_hi ? 2'd3 : s_col_q[1:0];
    col_over = {1'b0, s_col_q[0]};
    for (int t = 0; t < TAPS; t++) begin
      d_tap[t]    = tap_dist(TAP_BITS'(t), row_lo, s_row_q[1:0], row_hi, row_over);
      k_tap[t]    = tap_dist(TAP_BITS'(t), col_lo, col_pos, col_hi, col_over);
      slot_tap[t] = slot_back(slot_q, d_tap[t]);
    end
  end

  // Line store banks
  for (genvar g = 0; g < ROW_SLOTS; g++) begin : g_bank
    gb5m_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_WIDTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (accept && pix_step && (slot_q == SLOT_BITS'(g))),
      .waddr_i (s_col_q),
      .wdata_i (pixel_in_i),
      .re_i    (accept && step),
      .raddr_i (s_col_q),
      .rdata_o (rd_data[g])
    );
  end

  // Assemble the column, shift the window and form column sums
  always_comb begin
    for (int t = 0; t < TAPS; t++) begin
      if (dz1_q[t]) begin
        col_vec[t] = pix1_q;
      end else begin
        case (slot1_q[t])
          3'd0:    col_vec[t] = rd_data[0];
          3'd1:    col_vec[t] = rd_data[1];
          3'd2:    col_vec[t] = rd_data[2];
          3'd3:    col_vec[t] = rd_data[3];
          3'd4:    col_vec[t] = rd_data[4];
          3'd5:    col_vec[t] = rd_data[5];
          default: col_vec[t] = '0;
        endcase
      end
    end
    sr_d[0] = col_vec;
    for (int i = 1; i < TAPS; i++) begin
      sr_d[i] = sr_q[i-1];
    end
    for (int t = 0; t < TAPS; t++) begin
      case (k1_q[t])
        3'd0:    sel[t] = sr_d[0];
        3'd1:    sel[t] = sr_d[1];
        3'd2:    sel[t] = sr_d[2];
        3'd3:    sel[t] = sr_d[3];
        3'd4:    sel[t] = sr_d[4];
        default: sel[t] = '0;
      endcase
      psum2_d[t] = col_sum(TAP_BITS'(t), sel[t]);
    end
  end

  // Total with rounding bias, then divide by reciprocal multiply
  always_comb begin
    tot3_d = ROUND_BIAS;
    for (int t = 0; t < TAPS; t++) begin
      tot3_d = tot3_d + SUM_BITS'(psum2_q[t]);
    end
    prod = PROD_BITS'(tot3_q) * PROD_BITS'(RECIP_159);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      s_col_q  <= '0;
      s_row_q  <= '0;
      slot_q   <= '0;
      o_col_q  <= '0;
      o_row_q  <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      v4_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_WIDTH:  width_q  <= cfg_w;
          CFG_HEIGHT: height_q <= cfg_h;
          default:    width_q  <= width_q;
        endcase
        s_col_q <= '0;
        s_row_q <= '0;
        slot_q  <= '0;
        o_col_q <= '0;
        o_row_q <= '0;
      end else begin
        s_col_q <= s_col_d;
        s_row_q <= s_row_d;
        slot_q  <= slot_d;
        o_col_q <= o_col_d;
        o_row_q <= o_row_d;
      end
      if (ready1) begin
        v1_q <= accept && step;
      end
      if (ready2) begin
        v2_q <= v1_q && emit1_q;
      end
      if (ready3) begin
        v3_q <= v2_q;
      end
      if (ready4) begin
        v4_q <= v3_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept && step) begin
      emit1_q <= emit;
      last1_q <= last;
      pix1_q  <= pixel_in_i;
      for (int t = 0; t < TAPS; t++) begin
        dz1_q[t]   <= d_tap[t] == '0;
        slot1_q[t] <= slot_tap[t];
        k1_q[t]    <= k_tap[t];
      end
    end
    if (ready2 && v1_q) begin
      sr_q    <= sr_d;
      last2_q <= last1_q;
      psum2_q <= psum2_d;
    end
    if (ready3 && v2_q) begin
      tot3_q  <= tot3_d;
      last3_q <= last2_q;
    end
    if (ready4 && v3_q) begin
      pix4_q  <= prod[RECIP_SHIFT +: PIXEL_BITS];
      last4_q <= last3_q;
    end
  end

  assign out_valid_o  = v4_q;
  assign pixel_out_o  = pix4_q;
  assign frame_last_o = last4_q;

endmodule

>>> test/gaussian_blur_5x5_mirror_tb.sv
`timescale 1ns / 1ps

module gaussian_blur_5x5_mirror_tb;
  import gb5m_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [15:0] pix;
  } word_t;

  typedef struct packed {
    logic [15:0] pix;
    logic        last;
  } blur_t;

  localparam int TB_MAX_W = 1024;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic kind_i = 1'b0;
  logic [PIXEL_BITS-1:0] pixel_in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [PIXEL_BITS-1:0] pixel_out_o;
  logic frame_last_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;

  word_t word_q[$];
  blur_t blur_q[$];
  int errors = 0;
  int words_sent = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  logic took = 1'b0;

  // Shadow of the block's geometry, counters and line store
  int unsigned img_w = 640, img_h = 480;
  int unsigned in_col = 0, in_row = 0, out_col = 0, out_row = 0;
  logic [15:0] rows_mem [6*TB_MAX_W];

  gaussian_blur_5x5_mirror dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int mirror(int x, int n);
    if (x < 0) return -x;
    if (x >= n) return 2 * n - 1 - x;
    return x;
  endfunction

  function automatic void restart_frame();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  // Produce the next blurred pixel and advance the output position
  function automatic void emit_blur();
    longint unsigned acc;
    int r, c;
    int wts [5] = '{2, 4, 5, 4, 2};
    int ctr [5] = '{4, 9, 12, 9, 4};
    int mid [5] = '{5, 12, 15, 12, 5};
    int wt;
    blur_t b;
    acc = 0;
    for (int dr = -2; dr <= 2; dr++) begin
      r = mirror(int'(out_row) + dr, img_h) % 6;
      for (int dc = -2; dc <= 2; dc++) begin
        c = mirror(int'(out_col) + dc, img_w);
        if (dr == 0) wt = mid[dc + 2];
        else if (dr == -1 || dr == 1) wt = ctr[dc + 2];
        else wt = wts[dc + 2];
        acc += longint'(rows_mem[r * TB_MAX_W + c]) * wt;
      end
    end
    b.pix = 16'((acc + 79) / 159);
    b.last = 1'b0;
    out_col++;
    if (out_col >= img_w) begin
      out_col = 0;
      out_row++;
    end
    if (out_row >= img_h) begin
      b.last = 1'b1;
      restart_frame();
    end
    blur_q.push_back(b);
  endfunction

  function automatic void predict_word(word_t w);
    int unsigned in_idx, out_idx, total;
    bit done;
    in_idx = in_row * img_w + in_col;
    out_idx = out_row * img_w + out_col;
    total = img_w * img_h;
    done = in_row >= img_h;
    if (!w.kind && !done) begin
      rows_mem[(in_row % 6) * TB_MAX_W + in_col] = w.pix;
      in_col++;
      if (in_col >= img_w) begin
        in_col = 0;
        in_row++;
      end
      if (in_idx >= out_idx + 2 * img_w + 2) emit_blur();
    end else if (done && out_idx < total) begin
      emit_blur();
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Accept words, run the predictor on each
  always @(posedge clk_i) begin
    took <= in_valid_i && !in_stall_o;
    if (in_valid_i && !in_stall_o) predict_word('{kind: kind_i, pix: pixel_in_i});
  end

  // Drive the next word at the falling edge, hold it while stalled
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || took)) begin
      if (word_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        word_t w;
        w = word_q.pop_front();
        kind_i <= w.kind;
        pixel_in_i <= w.pix;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Check every accepted result against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (blur_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result pix=%0d", pixel_out_o));
      end else begin
        blur_t b;
        b = blur_q.pop_front();
        if (pixel_out_o !== b.pix)
          report_mismatch($sformatf("pixel_out got %0d want %0d", pixel_out_o, b.pix));
        if (frame_last_o !== b.last)
          report_mismatch($sformatf("frame_last got %0b want %0b", frame_last_o, b.last));
      end
    end
  end

  task automatic write_reg(cfg_reg_e idx, int unsigned val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= CFG_DATA_BITS'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_WIDTH) begin
      img_w = val & 32'h7FF;
      if (img_w < 3) img_w = 3;
      if (img_w > TB_MAX_W) img_w = TB_MAX_W;
    end else begin
      img_h = val & 32'h1FFF;
      if (img_h < 3) img_h = 3;
      if (img_h > 4096) img_h = 4096;
    end
    restart_frame();
  endtask

  task automatic push_word(bit k, int unsigned p);
    word_q.push_back('{kind: k, pix: 16'(p)});
    words_sent++;
  endtask

  // Queue one frame: style 0 random, 1 all max, 2 mixed extremes; noise adds stray words
  task automatic queue_frame(int style, bit noise);
    int unsigned p;
    for (int i = 0; i < img_w * img_h; i++) begin
      case (style)
        1: p = 16'hFFFF;
        2: p = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        default: p = $urandom;
      endcase
      if (noise && $urandom_range(9) == 0) push_word(1'b1, $urandom);
      push_word(1'b0, p);
    end
    // Flush: stray pixels here act as drain words
    for (int i = 0; i < 2 * img_w + 2; i++)
      push_word(noise && $urandom_range(3) == 0 ? 1'b0 : 1'b1, $urandom);
    if (noise) push_word(1'b1, $urandom);
  endtask

  task automatic wait_idle();
    while (word_q.size() > 0 || in_valid_i || blur_q.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Smallest frame via clamping from zero, saturated pixels, stray drains
    write_reg(CFG_WIDTH, 0);
    write_reg(CFG_HEIGHT, 0);
    push_word(1'b1, 16'h1234);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) push_word(1'b1, 0);
      push_word(1'b0, i[0] ? 16'hFFFF : 16'h0000);
    end
    push_word(1'b0, 16'hFFFF);
    for (int i = 0; i < 7; i++) push_word(1'b1, 0);
    push_word(1'b1, 0);
    push_word(1'b1, 0);
    wait_idle();

    write_reg(CFG_WIDTH, 3);
    queue_frame(1, 1'b0);
    wait_idle();

    // Widest frame via clamping from above, abandoned before its first result
    write_reg(CFG_WIDTH, 2047);
    write_reg(CFG_HEIGHT, 3);
    for (int i = 0; i < 40; i++) push_word(1'b0, $urandom);
    wait_idle();

    // Tallest frame via clamping from above, abandoned after a few rows
    write_reg(CFG_WIDTH, 3);
    write_reg(CFG_HEIGHT, 8191);
    for (int i = 0; i < 30; i++) push_word(1'b0, $urandom);
    wait_idle();

    // Abandon a frame part way, then run a full one
    write_reg(CFG_WIDTH, 5);
    write_reg(CFG_HEIGHT, 5);
    for (int i = 0; i < 17; i++) push_word(1'b0, $urandom);
    wait_idle();
    write_reg(CFG_HEIGHT, 4);
    queue_frame(0, 1'b1);
    wait_idle();

    // Random frames over the idling phases
    for (int n = 0; words_sent < 1150; n++) begin
      case ((n / 4) % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 74; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 74; end
        default: begin send_idle_pct = 20; stall_pct = 20; end
      endcase
      write_reg(CFG_WIDTH, $urandom_range(12, 3));
      write_reg(CFG_HEIGHT, $urandom_range(6, 3));
      queue_frame($urandom_range(4) == 0 ? 2 : 0, $urandom_range(1));
      wait_idle();
    end

    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> files.f
src/gb5m_pkg.sv
src/gb5m_ram.sv
src/gaussian_blur_5x5_mirror.sv
test/gaussian_blur_5x5_mirror_tb.sv
